// ===== hw/rtl/ibsf_pkg.sv =====
// shared types and constants of the byte stuffing framer
package ibsf_pkg;

  localparam logic [7:0] FlagByte = 8'h7E;
  localparam logic [7:0] EscByte  = 8'h7D;
  localparam logic [7:0] EscMask  = 8'h20;
  localparam logic       SeqToggle = 1'b1;

  // longest line sequence one word can cause: header, stuffed data, stuffed bcc, flag
  localparam int unsigned MaxBytes = 9;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);

  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 32;

  typedef enum logic [1:0] {
    RegAddress  = 2'd0,
    RegCtrlSeq0 = 2'd1,
    RegCtrlSeq1 = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] address_byte;
    logic [7:0] control_seq0;
    logic [7:0] control_seq1;
  } cfg_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
    logic                     closes;
  } line_list_t;

  function automatic logic needs_stuff(input logic [7:0] b);
    return (b == FlagByte) || (b == EscByte);
  endfunction

endpackage

// ===== hw/rtl/ibsf_if.sv =====
// handshake channels for payload words and line words
interface ibsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ibsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

// ===== hw/rtl/ibsf_regs.sv =====
// apb configuration registers: address and the two control bytes
module ibsf_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ibsf_pkg::PaddrW-1:0] paddr,
  input  logic [ibsf_pkg::PdataW-1:0] pwdata,
  output logic [ibsf_pkg::PdataW-1:0] prdata,
  output logic                        pready,
  output ibsf_pkg::cfg_t              cfg_o
);
  import ibsf_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegAddress:  cfg_d.address_byte = pwdata[7:0];
        RegCtrlSeq0: cfg_d.control_seq0 = pwdata[7:0];
        RegCtrlSeq1: cfg_d.control_seq1 = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      RegAddress:  prdata[7:0] = cfg_q.address_byte;
      RegCtrlSeq0: prdata[7:0] = cfg_q.control_seq0;
      RegCtrlSeq1: prdata[7:0] = cfg_q.control_seq1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.address_byte <= 8'h03;
      cfg_q.control_seq0 <= 8'h00;
      cfg_q.control_seq1 <= 8'h40;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  // a write to an unused address leaves every register alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && paddr[3:2] > RegCtrlSeq1) |=> $stable(cfg_q))
    else $error("write to unused address changed a register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && idx == RegAddress) |=> (cfg_q.address_byte == $past(pwdata[7:0])))
    else $error("address register not written");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_en |=> $stable(cfg_q))
    else $error("register changed without a write");
endmodule

// ===== hw/rtl/ibsf_build.sv =====
// input register, frame state and the combinational line byte list of one word
module ibsf_build (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ibsf_in_if.sink              in_i,
  input  ibsf_pkg::cfg_t       cfg_i,
  output ibsf_pkg::line_list_t list_o,
  output logic                 list_valid_o,
  input  logic                 list_ready_i
);
  import ibsf_pkg::*;

  logic            a_valid_q, a_valid_d;
  logic [7:0]      a_data_q;
  logic            a_last_q;
  logic            in_frame_q, in_frame_d;
  logic [7:0]      parity_q, parity_d;
  logic            seq_q, seq_d;
  logic            take;
  logic            list_fire;
  logic [7:0]      ctrl;
  logic [7:0]      par_new;
  logic [CntW-1:0] n;
  line_list_t      lst;

  assign list_fire    = a_valid_q && list_ready_i;
  assign in_i.ready   = !a_valid_q || list_ready_i;
  assign take         = in_i.valid && in_i.ready;
  assign list_valid_o = a_valid_q;
  assign list_o       = lst;

  assign ctrl    = seq_q ? cfg_i.control_seq1 : cfg_i.control_seq0;
  assign par_new = (in_frame_q ? parity_q : 8'h00) ^ a_data_q;

  always_comb begin
    lst   = '0;
    n     = '0;
    if (!in_frame_q) begin
      lst.bytes[0] = FlagByte;
      lst.bytes[1] = cfg_i.address_byte;
      lst.bytes[2] = ctrl;
      lst.bytes[3] = cfg_i.address_byte ^ ctrl;
      n = CntW'(4);
    end
    if (needs_stuff(a_data_q)) begin
      lst.bytes[n]               = EscByte;
      lst.bytes[CntW'(n + 1'b1)] = a_data_q ^ EscMask;
      n = CntW'(n + 2'd2);
    end else begin
      lst.bytes[n] = a_data_q;
      n = CntW'(n + 1'b1);
    end
    if (a_last_q) begin
      if (needs_stuff(par_new)) begin
        lst.bytes[n]               = EscByte;
        lst.bytes[CntW'(n + 1'b1)] = par_new ^ EscMask;
        n = CntW'(n + 2'd2);
      end else begin
        lst.bytes[n] = par_new;
        n = CntW'(n + 1'b1);
      end
      lst.bytes[n] = FlagByte;
      n = CntW'(n + 1'b1);
    end
    lst.count  = n;
    lst.closes = a_last_q;
  end

  always_comb begin
    a_valid_d  = a_valid_q;
    in_frame_d = in_frame_q;
    parity_d   = parity_q;
    seq_d      = seq_q;
    if (list_fire) begin
      a_valid_d = 1'b0;
      if (a_last_q) begin
        in_frame_d = 1'b0;
        parity_d   = 8'h00;
        seq_d      = seq_q ^ SeqToggle;
      end else begin
        in_frame_d = 1'b1;
        parity_d   = par_new;
      end
    end
    if (take) begin
      a_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q  <= 1'b0;
      in_frame_q <= 1'b0;
      parity_q   <= 8'h00;
      seq_q      <= 1'b0;
    end else begin
      a_valid_q  <= a_valid_d;
      in_frame_q <= in_frame_d;
      parity_q   <= parity_d;
      seq_q      <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_data_q <= in_i.data_byte;
      a_last_q <= in_i.last_byte;
    end
  end

  // bcc accumulator is cleared whenever no frame is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (parity_q == 8'h00))
    else $error("parity nonzero outside a frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    list_valid_o |-> (lst.count >= CntW'(1) && lst.count <= CntW'(MaxBytes)))
    else $error("line list count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (list_fire && a_last_q) |=> (seq_q != $past(seq_q)))
    else $error("sequence bit did not toggle at frame end");
endmodule

// ===== hw/rtl/ibsf_serializer.sv =====
// result register holding a word's line bytes, shifted out one per cycle while the output is ready
module ibsf_serializer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ibsf_pkg::line_list_t list_i,
  input  logic                 list_valid_i,
  output logic                 list_ready_o,
  ibsf_out_if.source           out_o
);
  import ibsf_pkg::*;

  logic [MaxBytes-1:0][7:0] buf_q, buf_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     closes_q;
  logic                     out_fire;
  logic                     load;

  assign out_fire     = out_o.valid && out_o.ready;
  // take the next list when empty or while the final byte leaves
  assign list_ready_o = (cnt_q == '0) || (cnt_q == CntW'(1) && out_o.ready);
  assign load         = list_valid_i && list_ready_o;

  assign out_o.valid     = (cnt_q != '0);
  assign out_o.out_byte  = buf_q[0];
  assign out_o.frame_end = closes_q && (cnt_q == CntW'(1));

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (load) begin
      buf_d = list_i.bytes;
      cnt_d = list_i.count;
    end else if (out_fire) begin
      for (int i = 0; i < MaxBytes - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (load) begin
      closes_q <= list_i.closes;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxBytes))
    else $error("serializer count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.frame_end |-> (out_o.valid && out_o.out_byte == FlagByte))
    else $error("frame end not on a flag byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !load) |=> (cnt_q == CntW'($past(cnt_q) - 1'b1)))
    else $error("count not decremented on a sent byte");
endmodule

// ===== hw/rtl/iframe_byte_stuffing_framer_core.sv =====
// top level of the byte stuffing information frame framer
// Takes one payload word per handshake (data byte plus last-byte mark) and sends the
// framed line stream one byte per cycle while the output is ready. The first word of a
// frame is preceded by flag, address, control (picked by the alternating sequence
// bit) and their xor, none of them stuffed; 0x7E and 0x7D in the payload and in the
// bcc go out as 0x7D and the byte xor 0x20; the last word adds the bcc and a closing
// flag marked with frame_end. A word causes 1 to 9 line bytes on the output channel.
// The input register takes the next word while the serializer is still sending, so
// words that make one byte each sustain one word per cycle while the output is ready.
// Configuration writes take effect at the next frame header.
module iframe_byte_stuffing_framer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ibsf_in_if.sink                     in_i,
  ibsf_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ibsf_pkg::PaddrW-1:0] paddr,
  input  logic [ibsf_pkg::PdataW-1:0] pwdata,
  output logic [ibsf_pkg::PdataW-1:0] prdata,
  output logic                        pready
);
  import ibsf_pkg::*;

  cfg_t       cfg;
  line_list_t lst;
  logic       lst_valid;
  logic       lst_ready;

  ibsf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ibsf_build u_build (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg),
    .list_o       (lst),
    .list_valid_o (lst_valid),
    .list_ready_i (lst_ready)
  );

  ibsf_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .list_i       (lst),
    .list_valid_i (lst_valid),
    .list_ready_o (lst_ready),
    .out_o        (out_o)
  );
endmodule
